// ----- src/rcmt_pkg.sv -----
// ----------------------------------------------------------------------------
// rcmt_pkg: read command monitor tracer shared definitions
// Match codes, trace record layout, queue entry type and hex digit helper.
// ----------------------------------------------------------------------------
package rcmt_pkg;

   localparam logic [31:0] READ_CODE   = 32'h0000_0071;
   localparam logic [7:0]  READ_TAG    = 8'h71;
   localparam logic [31:0] BLOCK_BYTES = 32'h0000_0020;

   // trace record layout: 'R', 8 offset digits, ':', 8 length digits, newline
   localparam int          IDX_W       = 5;
   localparam logic [IDX_W-1:0] POS_TAG       = 5'd0;
   localparam logic [IDX_W-1:0] POS_OFS_FIRST = 5'd1;
   localparam logic [IDX_W-1:0] POS_OFS_LAST  = 5'd8;
   localparam logic [IDX_W-1:0] POS_SEP       = 5'd9;
   localparam logic [IDX_W-1:0] POS_LEN_FIRST = 5'd10;
   localparam logic [IDX_W-1:0] POS_LEN_LAST  = 5'd17;
   localparam logic [IDX_W-1:0] POS_EOL       = 5'd18;

   localparam logic [7:0] CHAR_TAG  = 8'h52;  // 'R'
   localparam logic [7:0] CHAR_SEP  = 8'h3A;  // ':'
   localparam logic [7:0] CHAR_EOL  = 8'h0A;  // newline
   localparam logic [7:0] CHAR_NONE = 8'h00;

   // one classified command, status already updated
   typedef struct packed {
      logic        was_read;
      logic        traced;
      logic [31:0] calls_seen;
      logic [31:0] reads_seen;
      logic [63:0] bytes_total;
      logic [31:0] recent_handle;
      logic [31:0] recent_offset;
      logic [31:0] recent_length;
   } entry_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      if (nibble < 4'd10) begin
         hex_char = 8'h30 + {4'h0, nibble};
      end else begin
         hex_char = 8'h57 + {4'h0, nibble};  // 'a' - 10
      end
   endfunction

endpackage

// ----- src/rcmt_req_if.sv -----
// ----------------------------------------------------------------------------
// rcmt_req_if: command event channel
// Valid/ready channel carrying one observed command event per word.
// ----------------------------------------------------------------------------
interface rcmt_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] handle;
   logic [31:0] command_code;
   logic [31:0] block_length;
   logic        block_present;
   logic [31:0] first_word;
   logic [31:0] read_length;
   logic [31:0] read_offset;

   modport source (output valid, handle, command_code, block_length, block_present,
                   first_word, read_length, read_offset, input ready);
   modport sink   (input valid, handle, command_code, block_length, block_present,
                   first_word, read_length, read_offset, output ready);
endinterface

// ----- src/rcmt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rcmt_rsp_if: result channel
// Valid/ready channel carrying one trace character or status word.
// ----------------------------------------------------------------------------
interface rcmt_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  trace_char;
   logic        char_valid;
   logic        last;
   logic        was_read;
   logic [31:0] calls_seen;
   logic [31:0] reads_seen;
   logic [63:0] bytes_total;
   logic [31:0] recent_handle;
   logic [31:0] recent_offset;
   logic [31:0] recent_length;

   modport source (output valid, trace_char, char_valid, last, was_read, calls_seen,
                   reads_seen, bytes_total, recent_handle, recent_offset, recent_length,
                   input ready);
   modport sink   (input valid, trace_char, char_valid, last, was_read, calls_seen,
                   reads_seen, bytes_total, recent_handle, recent_offset, recent_length,
                   output ready);
endinterface

// ----- src/rcmt_csr_if.sv -----
// ----------------------------------------------------------------------------
// rcmt_csr_if: configuration write channel
// Valid/ready channel carrying the trace enable write data.
// ----------------------------------------------------------------------------
interface rcmt_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- src/rcmt_front.sv -----
// ----------------------------------------------------------------------------
// rcmt_front: command classifier and statistics
// Accepts command words, detects disc reads, updates counters, queues status.
// ----------------------------------------------------------------------------
module rcmt_front (
   input  logic                 clock,
   input  logic                 reset,
   rcmt_req_if.sink             req_chan,
   input  logic                 trace_enable,
   input  logic                 queue_full,
   output logic                 push,
   output rcmt_pkg::entry_type  push_entry
);

   logic [31:0] calls_ff,  calls_in;
   logic [31:0] reads_ff,  reads_in;
   logic [63:0] bytes_ff,  bytes_in;
   logic [31:0] handle_ff, handle_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] length_ff, length_in;
   logic        is_read;

   assign req_chan.ready = ~queue_full;
   assign push           = req_chan.valid & ~queue_full;

   assign is_read = (req_chan.command_code == rcmt_pkg::READ_CODE) &&
                    (req_chan.block_length == rcmt_pkg::BLOCK_BYTES) &&
                    req_chan.block_present &&
                    (req_chan.first_word[31:24] == rcmt_pkg::READ_TAG);

   always_comb begin
      calls_in  = calls_ff + 32'd1;
      reads_in  = reads_ff;
      bytes_in  = bytes_ff;
      handle_in = handle_ff;
      offset_in = offset_ff;
      length_in = length_ff;
      if (is_read) begin
         reads_in  = reads_ff + 32'd1;
         bytes_in  = bytes_ff + {32'd0, req_chan.read_length};
         handle_in = req_chan.handle;
         offset_in = req_chan.read_offset;
         length_in = req_chan.read_length;
      end
   end

   always_comb begin
      push_entry.was_read      = is_read;
      push_entry.traced        = is_read & trace_enable;
      push_entry.calls_seen    = calls_in;
      push_entry.reads_seen    = reads_in;
      push_entry.bytes_total   = bytes_in;
      push_entry.recent_handle = handle_in;
      push_entry.recent_offset = offset_in;
      push_entry.recent_length = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calls_ff  <= '0;
         reads_ff  <= '0;
         bytes_ff  <= '0;
         handle_ff <= '0;
         offset_ff <= '0;
         length_ff <= '0;
      end else if (push) begin
         calls_ff  <= calls_in;
         reads_ff  <= reads_in;
         bytes_ff  <= bytes_in;
         handle_ff <= handle_in;
         offset_ff <= offset_in;
         length_ff <= length_in;
      end
   end

endmodule

// ----- src/rcmt_queue.sv -----
// ----------------------------------------------------------------------------
// rcmt_queue: classified command queue
// Small register FIFO between the classifier and the serializer.
// ----------------------------------------------------------------------------
module rcmt_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rcmt_pkg::entry_type  push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output rcmt_pkg::entry_type  head_entry
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   rcmt_pkg::entry_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign full       = (count_ff == FULL_CNT);
   assign empty      = (count_ff == '0);
   assign head_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- src/rcmt_back.sv -----
// ----------------------------------------------------------------------------
// rcmt_back: result serializer
// Turns one queued entry into a status word or a 19-character trace record.
// ----------------------------------------------------------------------------
module rcmt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_empty,
   input  rcmt_pkg::entry_type  head_entry,
   output logic                 pop,
   rcmt_rsp_if.source           rsp_chan
);

   rcmt_pkg::entry_type               entry_ff;
   logic                              busy_ff, busy_in;
   logic [rcmt_pkg::IDX_W-1:0]        idx_ff,  idx_in;
   logic                              fire;
   logic                              is_last;
   logic [rcmt_pkg::IDX_W-1:0]        ofs_pos;
   logic [rcmt_pkg::IDX_W-1:0]        len_pos;
   logic [7:0]                        char_code;

   assign fire    = busy_ff & rsp_chan.ready;
   assign is_last = ~entry_ff.traced | (idx_ff == rcmt_pkg::POS_EOL);
   // load when idle, or right behind the final word of the current entry
   assign pop     = ~queue_empty & (~busy_ff | (fire & is_last));

   // nibble number, most significant first
   assign ofs_pos = rcmt_pkg::POS_OFS_LAST - idx_ff;
   assign len_pos = rcmt_pkg::POS_LEN_LAST - idx_ff;

   always_comb begin
      case (idx_ff) inside
         rcmt_pkg::POS_TAG: char_code = rcmt_pkg::CHAR_TAG;
         [rcmt_pkg::POS_OFS_FIRST:rcmt_pkg::POS_OFS_LAST]:
            char_code = rcmt_pkg::hex_char(entry_ff.recent_offset[{ofs_pos[2:0], 2'b00} +: 4]);
         rcmt_pkg::POS_SEP: char_code = rcmt_pkg::CHAR_SEP;
         [rcmt_pkg::POS_LEN_FIRST:rcmt_pkg::POS_LEN_LAST]:
            char_code = rcmt_pkg::hex_char(entry_ff.recent_length[{len_pos[2:0], 2'b00} +: 4]);
         default: char_code = rcmt_pkg::CHAR_EOL;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (fire) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + rcmt_pkg::IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         entry_ff <= head_entry;
      end
   end

   assign rsp_chan.valid         = busy_ff;
   assign rsp_chan.trace_char    = entry_ff.traced ? char_code : rcmt_pkg::CHAR_NONE;
   assign rsp_chan.char_valid    = entry_ff.traced;
   assign rsp_chan.last          = is_last;
   assign rsp_chan.was_read      = entry_ff.was_read;
   assign rsp_chan.calls_seen    = entry_ff.calls_seen;
   assign rsp_chan.reads_seen    = entry_ff.reads_seen;
   assign rsp_chan.bytes_total   = entry_ff.bytes_total;
   assign rsp_chan.recent_handle = entry_ff.recent_handle;
   assign rsp_chan.recent_offset = entry_ff.recent_offset;
   assign rsp_chan.recent_length = entry_ff.recent_length;

endmodule

// ----- src/read_command_monitor_tracer_core.sv -----
// ----------------------------------------------------------------------------
// read_command_monitor_tracer_core: disc read command monitor and tracer
// Counts command events, totals disc read bytes and emits text trace records.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan  - one observed command event per word (valid/ready).
//   rsp_chan  - result words. A non-read, or a read with tracing off, gives
//               one status word with last set. A traced read gives 19 words,
//               one character each: 'R', 8 hex digits of the offset, ':',
//               8 hex digits of the length, newline (last on the newline).
//               Every word carries the statistics after that command.
//   csr_chan  - writes trace_enable; always ready. Write only while idle.
// Result path: an accepted command is written into the queue, then loaded into
//   the serializer register, which presents the first result word.
// Throughput: the serializer emits one character per cycle while rsp_chan.ready
//   is high. The classifier keeps taking commands while the serializer works,
//   until the queue fills.
// Reset: all counters, saved fields and trace_enable clear; queue empties.
// Stall: while rsp_chan.ready is low the current word holds; commands are
//   still taken until QUEUE_DEPTH entries wait, then req_chan.ready drops.
// ----------------------------------------------------------------------------
module read_command_monitor_tracer_core #(
   parameter int QUEUE_DEPTH = 2   // entries between classifier and serializer, >= 2
) (
   input  logic        clock,
   input  logic        reset,
   rcmt_req_if.sink    req_chan,
   rcmt_rsp_if.source  rsp_chan,
   rcmt_csr_if.sink    csr_chan
);

   logic                trace_enable_ff;
   logic                queue_full;
   logic                queue_empty;
   logic                push;
   logic                pop;
   rcmt_pkg::entry_type push_entry;
   rcmt_pkg::entry_type head_entry;

   // configuration register: single bit, taken any cycle
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_enable_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         trace_enable_ff <= csr_chan.data;
      end
   end

   // front: classify and update statistics, one command per cycle while the queue is not full
   rcmt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .trace_enable (trace_enable_ff),
      .queue_full   (queue_full),
      .push         (push),
      .push_entry   (push_entry)
   );

   // decoupling queue
   rcmt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head_entry (head_entry)
   );

   // back: serialize status words and trace characters
   rcmt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_entry  (head_entry),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule
